FILE: src/alsa_pkg.sv
// Shared types and constants for the aligned LIFO stack allocator.
// No dependencies; imported by alsa_ctrl and aligned_lifo_stack_allocator_unit.
`default_nettype none

package alsa_pkg;

	localparam int unsigned DEF_STACK_DEPTH = 64;
	localparam int unsigned HEADER_BYTES    = 16;
	localparam int unsigned MAX_ALIGN_LOG2  = 12;
	localparam int unsigned FRAME_W         = 64;
	localparam int unsigned PAD_W           = 14;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_FREE_IGN = 2'd3;

	localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_REGION_BYTES = 2'd1;
	localparam logic [1:0] REG_START_OFFSET = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] request_bytes;
		logic [3:0]  align_log2;
		logic [31:0] free_address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_address;
		logic [31:0] used_offset;
		logic [31:0] peak_offset;
	} rsp_t;

	typedef struct packed {
		logic [31:0] base_address;
		logic [31:0] region_bytes;
		logic [11:0] start_offset;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/alsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module alsa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/alsa_ctrl.sv
// Command sequencer: offset, peak and frame count registers, padding and
// range checks, and read-modify-write of the frame memory. Uses alsa_pkg.
`default_nettype none

module alsa_ctrl #(
	parameter int unsigned STACK_DEPTH = alsa_pkg::DEF_STACK_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire alsa_pkg::cfg_t                 cfg,
	input  wire logic                           cmd_valid,
	output logic                                cmd_ready,
	input  wire alsa_pkg::cmd_t                 cmd,
	output logic                                done,
	output alsa_pkg::rsp_t                      result,
	input  wire logic                           result_space,
	output logic                                mem_we,
	output logic [$clog2(STACK_DEPTH)-1:0]      mem_waddr,
	output logic [alsa_pkg::FRAME_W-1:0]        mem_wdata,
	output logic                                mem_re,
	output logic [$clog2(STACK_DEPTH)-1:0]      mem_raddr,
	input  wire logic [alsa_pkg::FRAME_W-1:0]   mem_rdata
);
	import alsa_pkg::*;

	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t           state_q;
	cmd_t             item_s1;
	logic [PAD_W-1:0] pad_s1;
	logic [32:0]      addr_s1;
	logic [32:0]      end_s1;
	logic [31:0]      used_q;
	logic [31:0]      peak_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic [11:0]      addr_lo;
	logic [3:0]       lg;
	logic [11:0]      mask;
	logic [11:0]      pad_p;
	logic [12:0]      hdr_sum;
	logic [12:0]      hdr;
	logic [PAD_W-1:0] pad;
	logic [CNT_W-1:0] count_dec;

	logic [33:0]      new_used;
	logic             oom;
	logic             full;
	logic [31:0]      blk;
	logic             free_ok;
	logic             alloc_ok;
	logic             finish;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// padding from the low address bits; alignment is at most 4 KiB
	always_comb begin
		addr_lo = cfg.base_address[11:0] + used_q[11:0];
		lg      = (cmd.align_log2 > 4'(MAX_ALIGN_LOG2)) ? 4'(MAX_ALIGN_LOG2) : cmd.align_log2;
		mask    = 12'((13'd1 << lg) - 13'd1);
		pad_p   = (12'd0 - addr_lo) & mask;
		hdr_sum = 13'(HEADER_BYTES) + {1'b0, mask};
		hdr     = hdr_sum & ~{1'b0, mask};
		if ({2'b00, pad_p} >= PAD_W'(HEADER_BYTES)) begin
			pad = {2'b00, pad_p};
		end else begin
			pad = {2'b00, pad_p} + {1'b0, hdr};
		end
	end

	assign count_dec = count_q - CNT_W'(1);
	assign mem_re    = accept;
	assign mem_raddr = count_dec[IDX_W-1:0];

	always_comb begin
		new_used = {2'b00, used_q} + {{(34-PAD_W){1'b0}}, pad_s1} +
			{2'b00, item_s1.request_bytes};
		oom      = new_used > {2'b00, cfg.region_bytes};
		full     = count_q >= CNT_W'(STACK_DEPTH);
		blk      = addr_s1[31:0] + {{(32-PAD_W){1'b0}}, pad_s1};
		free_ok  = (count_q != '0) &&
			({1'b0, item_s1.free_address} >= {1'b0, cfg.base_address}) &&
			({1'b0, item_s1.free_address} < end_s1) &&
			({1'b0, item_s1.free_address} < addr_s1) &&
			(mem_rdata[63:32] == item_s1.free_address);
		alloc_ok = (item_s1.command == CMD_ALLOC) && !oom && !full;
		finish   = (state_q == S_EXEC) && result_space;
	end

	assign done      = finish;
	assign mem_we    = finish && alloc_ok;
	assign mem_waddr = count_q[IDX_W-1:0];
	assign mem_wdata = {blk, used_q};

	always_comb begin
		result.status        = ST_OK;
		result.block_address = '0;
		result.used_offset   = used_q;
		result.peak_offset   = peak_q;
		case (item_s1.command)
			CMD_ALLOC: begin
				if (oom) begin
					result.status = ST_OOM;
				end else if (full) begin
					result.status = ST_FULL;
				end else begin
					result.block_address = blk;
					result.used_offset   = new_used[31:0];
					result.peak_offset   = (new_used[31:0] > peak_q) ? new_used[31:0] : peak_q;
				end
			end
			CMD_FREE: begin
				if (free_ok) begin
					result.used_offset = mem_rdata[31:0];
				end else begin
					result.status = ST_FREE_IGN;
				end
			end
			CMD_RESET: begin
				result.used_offset = {20'd0, cfg.start_offset};
				result.peak_offset = {20'd0, cfg.start_offset};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
			pad_s1  <= pad;
			addr_s1 <= {1'b0, cfg.base_address} + {1'b0, used_q};
			end_s1  <= {1'b0, cfg.base_address} + {1'b0, cfg.region_bytes};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			peak_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q <= S_IDLE;
						used_q  <= result.used_offset;
						peak_q  <= result.peak_offset;
						if (alloc_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else if (item_s1.command == CMD_FREE && free_ok) begin
							count_q <= count_dec;
						end else if (item_s1.command == CMD_RESET) begin
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/aligned_lifo_stack_allocator_unit.sv
// Aligned LIFO stack allocator: configuration registers, result register,
// sequencer and frame memory. Uses alsa_pkg, alsa_ctrl and alsa_ram.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes allocate, free and reset
//   commands; rsp channel (rsp_valid/rsp_ready/rsp) returns one item per
//   command, in order. cfg_we/cfg_index/cfg_data write base address (0),
//   region size (1) and start offset (2); the user must write them only
//   while idle, the block itself does not enforce it. A new item is
//   accepted only after the last has finished, due to the frame memory
//   read-modify-write (read the top frame, then update and write back).
//   cmd_ready stays low in the execute state, in which the top frame read
//   data is checked, the update is formed and the result register loads.
//   When rsp_ready is low, the result register holds; the next item may
//   still be accepted, but waits in the execute state until the result
//   register frees up. Reset clears offsets, peak, frame count and the
//   configuration registers to zero; the frame memory is not cleared, as
//   a frame is only used after it was pushed. A reset command applies
//   start_offset.
`default_nettype none

module aligned_lifo_stack_allocator_unit #(
	parameter int unsigned STACK_DEPTH = alsa_pkg::DEF_STACK_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire alsa_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output alsa_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);
	import alsa_pkg::*;

	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

	cfg_t               cfg_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;
	logic               done;
	rsp_t               result;
	logic               result_space;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [FRAME_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	logic [FRAME_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data;
				REG_REGION_BYTES: cfg_q.region_bytes <= cfg_data;
				REG_START_OFFSET: cfg_q.start_offset <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	assign result_space = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	alsa_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.result_space (result_space),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	alsa_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(STACK_DEPTH)
	) u_frames (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
